// ----- design/isolcs_pkg.sv -----
// ----------------------------------------------------------------------------
// isolcs_pkg
// Shared constants, request types and edge codes of the isoline cell block.
// ----------------------------------------------------------------------------
package isolcs_pkg;

    localparam int SCALAR_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int QW          = FRAC_BITS + 1;
    localparam int DW          = SCALAR_BITS + FRAC_BITS + 1;
    localparam int AW          = SCALAR_BITS + 3;
    localparam int NUM_LANES   = 4;

    localparam logic [2:0] EDGE_12 = 3'd0;
    localparam logic [2:0] EDGE_34 = 3'd1;
    localparam logic [2:0] EDGE_13 = 3'd2;
    localparam logic [2:0] EDGE_24 = 3'd3;
    localparam logic [2:0] EDGE_23 = 3'd4;

    typedef struct packed {
        logic                          func;
        logic signed [SCALAR_BITS-1:0] corner_a;
        logic signed [SCALAR_BITS-1:0] corner_b;
        logic signed [SCALAR_BITS-1:0] corner_c;
        logic signed [SCALAR_BITS-1:0] corner_d;
    } t_in_req;

    typedef struct packed {
        logic [2:0]    start_edge;
        logic [QW-1:0] start_frac;
        logic [2:0]    end_edge;
        logic [QW-1:0] end_frac;
        logic          last;
    } t_out_req;

    typedef struct packed {
        logic                                  v;
        logic                                  is_tri;
        logic [2:0]                            n;
        logic [1:0]                            idx0;
        logic [1:0]                            idx1;
        logic [NUM_LANES-1:0][SCALAR_BITS-1:0] num;
        logic [NUM_LANES-1:0][SCALAR_BITS-1:0] den;
        logic signed [AW-1:0]                  a;
        logic signed [AW-1:0]                  b;
        logic signed [AW-1:0]                  c;
        logic signed [AW-1:0]                  g1;
    } t_sa;

    typedef struct packed {
        logic                                  v;
        logic                                  is_tri;
        logic [2:0]                            n;
        logic [1:0]                            idx0;
        logic [1:0]                            idx1;
        logic [NUM_LANES-1:0][DW-1:0]          dd;
        logic [NUM_LANES-1:0][SCALAR_BITS-1:0] den;
        logic [NUM_LANES-1:0][SCALAR_BITS-1:0] rem;
        logic                                  dec;
        logic                                  dval;
        logic [2*AW-1:0]                       nb2;
        logic [2*AW-1:0]                       a4c;
    } t_sb;

    typedef struct packed {
        logic                                  v;
        logic                                  is_tri;
        logic [2:0]                            n;
        logic [1:0]                            idx0;
        logic [1:0]                            idx1;
        logic                                  hit;
        logic [NUM_LANES-1:0][DW-1:0]          dd;
        logic [NUM_LANES-1:0][SCALAR_BITS-1:0] den;
        logic [NUM_LANES-1:0][SCALAR_BITS-1:0] rem;
        logic [NUM_LANES-1:0][QW-1:0]          q;
    } t_dv;

    function automatic logic signed [AW-1:0] sx(input logic [SCALAR_BITS-1:0] x);
        sx = $signed({{3{x[SCALAR_BITS-1]}}, x});
    endfunction

    function automatic logic [2:0] lane_edge(input logic [1:0] l, input logic is_tri);
        case (l)
            2'd0:    lane_edge = EDGE_12;
            2'd1:    lane_edge = is_tri ? EDGE_23 : EDGE_34;
            2'd2:    lane_edge = EDGE_13;
            default: lane_edge = EDGE_24;
        endcase
    endfunction

endpackage

// ----- design/iso_line_cell_segments.sv -----
// ----------------------------------------------------------------------------
// iso_line_cell_segments
// Marching squares / triangles isoline segments of one grid cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one cell request:
//   mode plus four corner scalars. Output channel (o_out_valid / i_out_ready /
//   o_out_data) delivers zero, one or two segment requests per cell, last set
//   on the final one. i_cfg_we / i_cfg_wdata write the iso level; write it
//   only while the block is empty.
//   A request passes two setup stages, then one quotient bit per stage of
//   the fraction divider. Throughput: one cell per cycle for cells with zero
//   or one segment while the receiver does not stall; a saddle holds the
//   pipeline for its second segment, set by the single output port.
//   Reset clears all stage valid bits and sets the iso level to 0.
//   When the receiver stalls, the whole pipeline holds, bubbles included, and
//   the input is held off; a request is never dropped or repeated.
// ----------------------------------------------------------------------------
module iso_line_cell_segments (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [isolcs_pkg::SCALAR_BITS-1:0]        i_cfg_wdata,
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  isolcs_pkg::t_in_req                       i_in_data,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output isolcs_pkg::t_out_req                      o_out_data
);

    localparam int S = isolcs_pkg::SCALAR_BITS;
    localparam int F = isolcs_pkg::FRAC_BITS;
    localparam int L = isolcs_pkg::NUM_LANES;

    logic signed [S-1:0] r_iso;
    isolcs_pkg::t_sa     r_sa, n_sa;
    isolcs_pkg::t_sb     r_sb, n_sb;
    isolcs_pkg::t_dv     dv_in;
    isolcs_pkg::t_dv     r_dv [0:F];
    isolcs_pkg::t_dv     n_dv [0:F];
    logic                r_seg;
    logic                adv;
    logic                has_seg;
    logic                leave;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso <= '0;
        end else if (i_cfg_we) begin
            r_iso <= i_cfg_wdata;
        end
    end

    // stage A: crossings, numerators, denominators, quadratic coefficients
    always_comb begin
        logic signed [S-1:0] p [L];
        logic signed [S-1:0] q [L];
        logic [L-1:0]        cr;
        logic                gp;
        logic signed [S:0]   dn;
        logic signed [S:0]   dd;
        logic signed [isolcs_pkg::AW-1:0] e1, e2, e3, e4, ei;
        logic                is_tri;
        is_tri = i_in_data.func;
        p[0]  = i_in_data.corner_a;  q[0] = i_in_data.corner_b;
        p[1]  = is_tri ? i_in_data.corner_b : i_in_data.corner_c;
        q[1]  = is_tri ? i_in_data.corner_c : i_in_data.corner_d;
        p[2]  = i_in_data.corner_a;  q[2] = i_in_data.corner_c;
        p[3]  = i_in_data.corner_b;  q[3] = i_in_data.corner_d;
        n_sa        = '0;
        n_sa.v      = i_in_valid;
        n_sa.is_tri = is_tri;
        for (int l = 0; l < L; l++) begin
            gp    = p[l] > r_iso;
            cr[l] = gp != (q[l] > r_iso);
            if (l == 3) cr[l] = cr[l] & ~is_tri;
            dn = gp ? ({p[l][S-1], p[l]} - {r_iso[S-1], r_iso})
                    : ({r_iso[S-1], r_iso} - {p[l][S-1], p[l]});
            dd = gp ? ({p[l][S-1], p[l]} - {q[l][S-1], q[l]})
                    : ({q[l][S-1], q[l]} - {p[l][S-1], p[l]});
            n_sa.num[l] = dn[S-1:0];
            n_sa.den[l] = dd[S-1:0];
        end
        for (int l = 0; l < L; l++) begin
            if (cr[l]) begin
                if (n_sa.n == 3'd0) n_sa.idx0 = 2'(l);
                else if (n_sa.n == 3'd1) n_sa.idx1 = 2'(l);
                n_sa.n = n_sa.n + 3'd1;
            end
        end
        e1 = isolcs_pkg::sx(i_in_data.corner_a);
        e2 = isolcs_pkg::sx(i_in_data.corner_b);
        e3 = isolcs_pkg::sx(i_in_data.corner_c);
        e4 = isolcs_pkg::sx(i_in_data.corner_d);
        ei = isolcs_pkg::sx(r_iso);
        n_sa.a  = e1 - e2 - e3 + e4;
        n_sa.b  = e2 + e3 - (e1 <<< 1);
        n_sa.c  = e1 - ei;
        n_sa.g1 = e4 - ei;
    end

    // stage B: dividends, initial remainders, diagonal root test products
    always_comb begin
        logic signed [isolcs_pkg::AW-1:0] an, bn, cn;
        logic [isolcs_pkg::AW-1:0]        nbm, am4;
        logic [isolcs_pkg::DW-1:0]        d;
        n_sb        = '0;
        n_sb.v      = r_sa.v;
        n_sb.is_tri = r_sa.is_tri;
        n_sb.n      = r_sa.n;
        n_sb.idx0   = r_sa.idx0;
        n_sb.idx1   = r_sa.idx1;
        for (int l = 0; l < L; l++) begin
            d = (isolcs_pkg::DW'(r_sa.num[l]) << F) + isolcs_pkg::DW'(r_sa.den[l] >> 1);
            n_sb.dd[l]  = d;
            n_sb.den[l] = r_sa.den[l];
            n_sb.rem[l] = S'(d >> (F + 1));
        end
        an = r_sa.a;
        bn = r_sa.b;
        cn = r_sa.c;
        if (r_sa.a < 0) begin
            an = -r_sa.a;
            bn = -r_sa.b;
            cn = -r_sa.c;
        end
        if (r_sa.c == 0 || r_sa.g1 == 0) begin
            n_sb.dec  = 1'b1;
            n_sb.dval = 1'b1;
        end else if ((r_sa.c > 0) != (r_sa.g1 > 0)) begin
            n_sb.dec  = 1'b1;
            n_sb.dval = 1'b1;
        end else if (r_sa.a == 0) begin
            n_sb.dec  = 1'b1;
        end else if (cn <= 0 || -bn <= 0 || -bn >= (an <<< 1)) begin
            n_sb.dec  = 1'b1;
        end
        nbm      = -bn;
        am4      = an << 2;
        n_sb.nb2 = nbm * nbm;
        n_sb.a4c = am4 * cn;
    end

    always_comb begin
        dv_in        = '0;
        dv_in.v      = r_sb.v;
        dv_in.is_tri = r_sb.is_tri;
        dv_in.n      = r_sb.n;
        dv_in.idx0   = r_sb.idx0;
        dv_in.idx1   = r_sb.idx1;
        dv_in.hit    = r_sb.dec ? r_sb.dval : (r_sb.nb2 >= r_sb.a4c);
        dv_in.dd     = r_sb.dd;
        dv_in.den    = r_sb.den;
        dv_in.rem    = r_sb.rem;
    end

    // divider: one quotient bit per stage, MSB first
    for (genvar j = 0; j <= F; j++) begin : g_div
        localparam int K = F - j;
        always_comb begin
            logic [S:0] t;
            n_dv[j] = (j == 0) ? dv_in : r_dv[(j == 0) ? 0 : j - 1];
            for (int l = 0; l < L; l++) begin
                t = {n_dv[j].rem[l], n_dv[j].dd[l][K]};
                if (t >= {1'b0, n_dv[j].den[l]}) begin
                    t = t - {1'b0, n_dv[j].den[l]};
                    n_dv[j].q[l][K] = 1'b1;
                end
                n_dv[j].rem[l] = t[S-1:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j].v <= 1'b0;
            end else if (adv) begin
                r_dv[j] <= n_dv[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa.v <= 1'b0;
            r_sb.v <= 1'b0;
        end else if (adv) begin
            r_sa <= n_sa;
            r_sb <= n_sb;
        end
    end

    // output: pair crossings into segments
    always_comb begin
        logic [1:0] i0, i1;
        logic       lst;
        if (r_dv[F].n == 3'd4) begin
            i0  = r_seg ? 2'd1 : 2'd0;
            i1  = (r_dv[F].hit ^ r_seg) ? 2'd2 : 2'd3;
            lst = r_seg;
        end else begin
            i0  = r_dv[F].idx0;
            i1  = r_dv[F].idx1;
            lst = 1'b1;
        end
        has_seg                = r_dv[F].n == 3'd2 || r_dv[F].n == 3'd4;
        o_out_valid            = r_dv[F].v && has_seg;
        o_out_data.start_edge  = isolcs_pkg::lane_edge(i0, r_dv[F].is_tri);
        o_out_data.start_frac  = r_dv[F].q[i0];
        o_out_data.end_edge    = isolcs_pkg::lane_edge(i1, r_dv[F].is_tri);
        o_out_data.end_frac    = r_dv[F].q[i1];
        o_out_data.last        = lst;
        leave = r_dv[F].v && (!has_seg || (i_out_ready && lst));
        adv   = !r_dv[F].v || leave;
    end

    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_seg <= !o_out_data.last;
        end
    end

endmodule
